[design/ipaf_pkg.sv]
// Shared types, codes and character helpers for the IP address text formatter.
package ipaf_pkg;

  localparam int GROUP_COUNT = 8;
  localparam int V4_BYTES    = 4;

  // family codes on the input tuser
  localparam logic [1:0] FAMILY_V4 = 2'd0;
  localparam logic [1:0] FAMILY_V6 = 2'd1;

  // no zero run selected
  localparam logic [3:0] RUN_NONE = 4'd8;

  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_COLON = 7'h3a;

  typedef enum logic [1:0] {
    KIND_V4   = 2'd0,
    KIND_V6   = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  // one printed number: four digit slots, slot 0 in the top nibble
  typedef struct packed {
    logic [15:0] digits;
    logic [1:0]  first;   // first slot that is printed
  } field_t;

  typedef struct packed {
    kind_e                          kind;
    logic [3:0]                     zero_start;
    logic [3:0]                     best_len;
    field_t [GROUP_COUNT-1:0]       fields;
  } plan_t;

  function automatic logic [6:0] hex_char(logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = 7'h30 + {3'b000, d};
    end else begin
      c = 7'h57 + {3'b000, d};
    end
    return c;
  endfunction

endpackage

[design/ipaf_analyze.sv]
// Splits one registered address into printable fields and finds the zero run.
module ipaf_analyze (
  input  logic [1:0]     family_i,
  input  logic [63:0]    address_hi_i,
  input  logic [63:0]    address_lo_i,
  output ipaf_pkg::plan_t plan_o
);

  function automatic ipaf_pkg::field_t v4_field(logic [7:0] b);
    ipaf_pkg::field_t f;
    logic [1:0]  h;
    logic [6:0]  r;
    logic [13:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    if (b >= 8'd200) begin
      h = 2'd2;
    end else if (b >= 8'd100) begin
      h = 2'd1;
    end else begin
      h = 2'd0;
    end
    r = 7'(b - ({6'd0, h} * 8'd100));
    p = {7'd0, r} * 14'd103;   // r / 10 for r < 100
    t = p[13:10];
    o = r - ({3'b000, t} * 7'd10);
    f.digits = {4'd0, 2'b00, h, t, o[3:0]};
    if (b >= 8'd100) begin
      f.first = 2'd1;
    end else if (b >= 8'd10) begin
      f.first = 2'd2;
    end else begin
      f.first = 2'd3;
    end
    return f;
  endfunction

  function automatic ipaf_pkg::field_t v6_field(logic [15:0] g);
    ipaf_pkg::field_t f;
    f.digits = g;
    if (g[15:12] != 4'd0) begin
      f.first = 2'd0;
    end else if (g[11:8] != 4'd0) begin
      f.first = 2'd1;
    end else if (g[7:4] != 4'd0) begin
      f.first = 2'd2;
    end else begin
      f.first = 2'd3;
    end
    return f;
  endfunction

  logic [127:0] addr;
  logic [ipaf_pkg::GROUP_COUNT-1:0] zero;
  logic [3:0] run_len [ipaf_pkg::GROUP_COUNT];

  assign addr = {address_hi_i, address_lo_i};

  always_comb begin
    logic [3:0] run;
    logic [3:0] zero_start;
    logic [3:0] best_len;
    run        = 4'd0;
    zero_start = ipaf_pkg::RUN_NONE;
    best_len   = 4'd0;
    for (int i = 0; i < ipaf_pkg::GROUP_COUNT; i++) begin
      zero[i] = (addr[127-16*i -: 16] == 16'd0);
    end
    // zeros from each group onward, scanning from the right
    for (int i = ipaf_pkg::GROUP_COUNT - 1; i >= 0; i--) begin
      run = zero[i] ? run + 4'd1 : 4'd0;
      run_len[i] = run;
    end
    // strictly longer wins, so the first of equal runs is kept
    for (int i = 0; i < ipaf_pkg::GROUP_COUNT; i++) begin
      if (run_len[i] >= 4'd2 && run_len[i] > best_len) begin
        zero_start = 4'(i);
        best_len   = run_len[i];
      end
    end

    plan_o = '0;
    case (family_i)
      ipaf_pkg::FAMILY_V4: begin
        plan_o.kind       = ipaf_pkg::KIND_V4;
        plan_o.zero_start = ipaf_pkg::RUN_NONE;
        plan_o.best_len   = 4'd0;
        for (int i = 0; i < ipaf_pkg::V4_BYTES; i++) begin
          plan_o.fields[i] = v4_field(address_hi_i[63-8*i -: 8]);
        end
      end
      ipaf_pkg::FAMILY_V6: begin
        plan_o.kind       = ipaf_pkg::KIND_V6;
        plan_o.zero_start = zero_start;
        plan_o.best_len   = best_len;
        for (int i = 0; i < ipaf_pkg::GROUP_COUNT; i++) begin
          plan_o.fields[i] = v6_field(addr[127-16*i -: 16]);
        end
      end
      default: begin
        plan_o.kind       = ipaf_pkg::KIND_NONE;
        plan_o.zero_start = ipaf_pkg::RUN_NONE;
        plan_o.best_len   = 4'd0;
      end
    endcase
  end

endmodule

[design/ipaf_emit.sv]
// Walks one address plan and sends its text one character per cycle while the output is not stalled.
module ipaf_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ipaf_pkg::plan_t plan_i,
  input  logic            plan_valid_i,
  output logic            plan_take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [6:0]      out_char_o,
  output logic            out_last_o,
  output logic            out_empty_o
);

  typedef enum logic [2:0] {
    PH_EMPTY,
    PH_COLON_A,
    PH_COLON_B,
    PH_SEP,
    PH_DIGIT
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] d;
  } entry_t;

  // where printing of field fn begins
  function automatic entry_t enter_field(logic [3:0] fn, logic after_comp, logic is_v6,
                                         logic [3:0] zero_start, logic [1:0] first);
    entry_t e;
    e.d = first;
    if (is_v6 && fn == zero_start) begin
      e.phase = PH_COLON_A;
    end else if (fn != 4'd0 && !after_comp) begin
      e.phase = PH_SEP;
    end else begin
      e.phase = PH_DIGIT;
    end
    return e;
  endfunction

  logic             busy_q, busy_d;
  phase_e           phase_q, phase_d;
  logic [2:0]       f_q, f_d;
  logic [1:0]       d_q, d_d;
  ipaf_pkg::field_t cur_q, cur_d;
  ipaf_pkg::plan_t  plan_q, plan_d;
  logic             valid_q, valid_d;
  logic [6:0]       char_q, char_d;
  logic             last_q, last_d;
  logic             empty_q, empty_d;

  logic             adv;
  logic [6:0]       ch;
  logic             ch_last;
  logic             ch_empty;
  logic             take;

  always_comb begin
    logic       is_v6;
    logic [2:0] last_f;
    logic [3:0] span;
    logic [3:0] fn;
    logic       do_enter;
    logic       after_comp;
    entry_t     e;

    adv      = !valid_q || out_ready_i;
    is_v6    = (plan_q.kind == ipaf_pkg::KIND_V6);
    last_f   = is_v6 ? 3'd7 : 3'd3;
    span     = {1'b0, f_q} + plan_q.best_len;
    ch       = ipaf_pkg::CH_NUL;
    ch_last  = 1'b0;
    ch_empty = 1'b0;

    case (phase_q)
      PH_EMPTY: begin
        ch_last  = 1'b1;
        ch_empty = 1'b1;
      end
      PH_COLON_A: ch = ipaf_pkg::CH_COLON;
      PH_COLON_B: begin
        ch      = ipaf_pkg::CH_COLON;
        ch_last = (span == 4'd8);
      end
      PH_SEP:   ch = is_v6 ? ipaf_pkg::CH_COLON : ipaf_pkg::CH_DOT;
      PH_DIGIT: begin
        ch      = ipaf_pkg::hex_char(cur_q.digits[{~d_q, 2'b00} +: 4]);
        ch_last = (d_q == 2'd3) && (f_q == last_f);
      end
      default: ch = ipaf_pkg::CH_NUL;
    endcase

    take        = plan_valid_i && (!busy_q || (adv && ch_last));
    plan_take_o = take;

    busy_d     = busy_q;
    phase_d    = phase_q;
    f_d        = f_q;
    d_d        = d_q;
    cur_d      = cur_q;
    plan_d     = plan_q;
    fn         = 4'd0;
    do_enter   = 1'b0;
    after_comp = 1'b0;

    if (busy_q && adv) begin
      case (phase_q)
        PH_COLON_A: phase_d = PH_COLON_B;
        PH_COLON_B: begin
          fn         = span;
          do_enter   = !ch_last;
          after_comp = 1'b1;
        end
        PH_SEP: begin
          phase_d = PH_DIGIT;
          d_d     = cur_q.first;
        end
        PH_DIGIT: begin
          if (d_q != 2'd3) begin
            d_d = d_q + 2'd1;
          end else begin
            fn       = {1'b0, f_q} + 4'd1;
            do_enter = !ch_last;
          end
        end
        default: phase_d = phase_q;
      endcase
      if (ch_last) begin
        busy_d = 1'b0;
      end
    end

    e = enter_field(fn, after_comp, is_v6, plan_q.zero_start,
                    plan_q.fields[fn[2:0]].first);
    if (do_enter) begin
      f_d     = fn[2:0];
      cur_d   = plan_q.fields[fn[2:0]];
      phase_d = e.phase;
      d_d     = e.d;
    end

    if (take) begin
      busy_d = 1'b1;
      plan_d = plan_i;
      f_d    = 3'd0;
      cur_d  = plan_i.fields[0];
      e = enter_field(4'd0, 1'b0, plan_i.kind == ipaf_pkg::KIND_V6, plan_i.zero_start,
                      plan_i.fields[0].first);
      if (plan_i.kind == ipaf_pkg::KIND_NONE) begin
        phase_d = PH_EMPTY;
        d_d     = 2'd0;
      end else begin
        phase_d = e.phase;
        d_d     = e.d;
      end
    end

    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    empty_d = empty_q;
    if (adv) begin
      valid_d = busy_q;
      char_d  = ch;
      last_d  = ch_last;
      empty_d = ch_empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_EMPTY;
      f_q     <= 3'd0;
      d_q     <= 2'd0;
      cur_q   <= '0;
      plan_q  <= '0;
      valid_q <= 1'b0;
      char_q  <= '0;
      last_q  <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      f_q     <= f_d;
      d_q     <= d_d;
      cur_q   <= cur_d;
      plan_q  <= plan_d;
      valid_q <= valid_d;
      char_q  <= char_d;
      last_q  <= last_d;
      empty_q <= empty_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign out_empty_o = empty_q;

endmodule

[design/ip_address_text_formatter.sv]
// Top level of the IP address text formatter: input register, analysis, emitter.
//
// Usage:
//   Slave channel (s_axis_*): one request per address. tuser carries the family
//   (0 IPv4, 1 IPv6, anything else unsupported), tdata the 128 address bits.
//   Master channel (m_axis_*): the address text, one ASCII character per
//   transfer, tlast on the final character. tuser marks the single NUL
//   character sent for an unsupported family.
// Path: when the block is idle, an accepted address goes from the input
//   register through the stepper, whose first character enters the output register.
// Throughput: one character per cycle while m_axis_tready is high; a text is
//   7 to 15 characters long for IPv4, 2 to 39 for IPv6, 1 when unsupported.
//   The character stepper is the limit; the next address is analyzed in the
//   input register and handed over on the cycle the last character leaves.
// Reset: clears the input register valid, the stepper and the output valid;
//   no text is in flight afterwards.
// Stall: when m_axis_tready is low the output character holds and the
//   stepper waits; one further address may wait in the input register, after
//   which s_axis_tready drops.
module ip_address_text_formatter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // [63:0] address_hi, [127:64] address_lo
  input  logic [1:0]   s_axis_tuser,   // [1:0] family
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // [6:0] text_char, [7] zero fill
  output logic         m_axis_tlast,   // last_char
  output logic         m_axis_tuser    // [0] empty_text
);

  logic            in_valid_q, in_valid_d;
  logic [1:0]      in_family_q;
  logic [127:0]    in_data_q;
  ipaf_pkg::plan_t plan;
  logic            plan_take;
  logic            s_accept;
  logic [6:0]      out_char;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !in_valid_q || plan_take;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (plan_take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_family_q <= s_axis_tuser;
      in_data_q   <= s_axis_tdata;
    end
  end

  // group split, zero-run search and decimal conversion
  ipaf_analyze u_analyze (
    .family_i     (in_family_q),
    .address_hi_i (in_data_q[63:0]),
    .address_lo_i (in_data_q[127:64]),
    .plan_o       (plan)
  );

  // character stepper with the output register
  ipaf_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_i       (plan),
    .plan_valid_i (in_valid_q),
    .plan_take_o  (plan_take),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .out_last_o   (m_axis_tlast),
    .out_empty_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_char};

`ifndef SYNTHESIS
  // the empty marker is a lone NUL that closes its text
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("empty marker must be a final NUL character");

  // real text never carries NUL
  a_text_not_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != 8'd0)
    else $error("NUL inside address text");

  // a waiting address is not dropped while the stepper is busy
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !s_axis_tready |=> in_valid_q)
    else $error("pending address lost");

  // the stepper only takes a plan that is present
  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_take |-> in_valid_q)
    else $error("plan taken without an address");
`endif

endmodule
